### design/ltc_pkg.sv
// Shared types and constants for the least-used tag cache.
// No dependencies; compile first.
package ltc_pkg;

    localparam int KEY_W             = 32;
    localparam int SLOT_W            = 4;
    localparam int DEF_ENTRIES       = 16;
    localparam int DEF_COUNT_WIDTH   = 16;

    typedef enum logic [1:0] {
        FN_LOOKUP = 2'd0,
        FN_INSERT = 2'd1,
        FN_TOUCH  = 2'd2,
        FN_DIRTY  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ALU_EQ,
        ALU_LT,
        ALU_INC
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
    } alu_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EVSCAN,
        ST_INSTALL,
        ST_TOUCH_RD,
        ST_TOUCH_WR,
        ST_FINISH
    } state_t;

endpackage

### design/ltc_if.sv
// Request and response channel interfaces for the tag cache.
// Depends on ltc_pkg.
interface ltc_req_if;
    import ltc_pkg::*;

    logic                valid;
    logic                ready;
    func_t               func;
    logic [KEY_W-1:0]    object_key;
    logic [SLOT_W-1:0]   target_slot;
    logic                load_from_backing;

    modport source (output valid, func, object_key, target_slot, load_from_backing,
                    input ready);
    modport sink   (input valid, func, object_key, target_slot, load_from_backing,
                    output ready);
endinterface

interface ltc_rsp_if;
    import ltc_pkg::*;

    logic                valid;
    logic                ready;
    logic                hit;
    logic [SLOT_W-1:0]   result_slot;
    logic                writeback;
    logic [KEY_W-1:0]    victim_key;
    logic                fetch;

    modport source (output valid, hit, result_slot, writeback, victim_key, fetch,
                    input ready);
    modport sink   (input valid, hit, result_slot, writeback, victim_key, fetch,
                    output ready);
endinterface

### design/ltc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ltc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### design/ltc_alu.sv
// Shared compare/increment unit: key equality, count less-than, saturating increment.
// Depends on ltc_pkg.
module ltc_alu #(
    parameter int CNT_W = ltc_pkg::DEF_COUNT_WIDTH
) (
    input  ltc_pkg::alu_req_t  req,
    output logic               flag,
    output logic [CNT_W-1:0]   inc
);
    import ltc_pkg::*;

    logic [CNT_W-1:0] cnt;

    assign cnt = req.a[CNT_W-1:0];

    always_comb
    begin
        flag = 1'b0;
        inc  = cnt;
        case (req.op)
            ALU_EQ:  flag = (req.a == req.b);
            ALU_LT:  flag = (req.a < req.b);
            ALU_INC: inc  = (cnt == {CNT_W{1'b1}}) ? cnt : cnt + 1'b1;
            default: flag = 1'b0;
        endcase
    end
endmodule

### design/least_used_tag_cache_top.sv
// Least-used tag cache top: sequencer, dirty marks, key and count RAMs, shared ALU.
// Depends on ltc_pkg, ltc_if, ltc_ram and ltc_alu.
//
//   Channel  Dir  Handshake      Payload
//   req      in   valid/ready    func, object_key, target_slot, load_from_backing
//   rsp      out  valid/ready    hit, result_slot, writeback, victim_key, fetch
//
// One item at a time; req.ready is high only when the sequencer is idle.
// Lookup walks the filled slots through the key RAM, one slot per cycle; an eviction walks
// all ENTRIES counts. The RAM read port sets the pace.
// Reset clears state, fill level, dirty marks and the output valid; no clearing pass.
// A held response does not block the next request; only its own finish step waits.
module least_used_tag_cache_top #(
    parameter int ENTRIES     = ltc_pkg::DEF_ENTRIES,
    parameter int COUNT_WIDTH = ltc_pkg::DEF_COUNT_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    ltc_req_if.sink   req,
    ltc_rsp_if.source rsp
);
    import ltc_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);

    state_t                 state_reg, state_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [ENTRIES-1:0]     dirty_reg, dirty_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic                   out_vld_reg, out_vld_next;

    logic [IDX_W-1:0]       rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]       last_reg, last_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic                   load_reg, load_next;
    logic                   evict_reg, evict_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [COUNT_WIDTH-1:0] best_cnt_reg, best_cnt_next;
    logic [KEY_W-1:0]       best_key_reg, best_key_next;

    logic                   res_hit_reg, res_hit_next;
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic                   res_wb_reg, res_wb_next;
    logic [KEY_W-1:0]       res_vkey_reg, res_vkey_next;
    logic                   res_fetch_reg, res_fetch_next;

    logic                   out_hit_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic                   out_wb_reg;
    logic [KEY_W-1:0]       out_vkey_reg;
    logic                   out_fetch_reg;
    logic                   out_load;

    logic                   key_we, cnt_we;
    logic [IDX_W-1:0]       wr_addr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic [KEY_W-1:0]       key_rdata;
    logic [COUNT_WIDTH-1:0] cnt_rdata;

    alu_req_t               alu_req;
    logic                   alu_flag;
    logic [COUNT_WIDTH-1:0] alu_inc;

    logic                   req_xfer;
    logic                   target_ok;
    logic                   take_best;
    logic                   victim_dirty;

    ltc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (key_reg),
        .raddr (rd_addr_reg),
        .rdata (key_rdata)
    );

    ltc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ENTRIES)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (wr_addr),
        .wdata (cnt_wdata),
        .raddr (rd_addr_reg),
        .rdata (cnt_rdata)
    );

    ltc_alu #(.CNT_W(COUNT_WIDTH)) u_alu (
        .req  (alu_req),
        .flag (alu_flag),
        .inc  (alu_inc)
    );

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_xfer   = req.valid && req.ready;
    assign target_ok  = (32'(req.target_slot) < 32'(fill_reg));
    assign victim_dirty = evict_reg && dirty_reg[best_idx_reg];
    assign take_best  = (cmp_idx_reg == '0) || alu_flag;

    assign rsp.valid       = out_vld_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.result_slot = out_slot_reg;
    assign rsp.writeback   = out_wb_reg;
    assign rsp.victim_key  = out_vkey_reg;
    assign rsp.fetch       = out_fetch_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        dirty_next     = dirty_reg;
        cmp_vld_next   = 1'b0;
        rd_addr_next   = rd_addr_reg;
        cmp_idx_next   = rd_addr_reg;
        last_next      = last_reg;
        key_next       = key_reg;
        load_next      = load_reg;
        evict_next     = evict_reg;
        best_idx_next  = best_idx_reg;
        best_cnt_next  = best_cnt_reg;
        best_key_next  = best_key_reg;
        res_hit_next   = res_hit_reg;
        res_slot_next  = res_slot_reg;
        res_wb_next    = res_wb_reg;
        res_vkey_next  = res_vkey_reg;
        res_fetch_next = res_fetch_reg;
        key_we         = 1'b0;
        cnt_we         = 1'b0;
        wr_addr        = best_idx_reg;
        cnt_wdata      = '0;
        out_load       = 1'b0;
        alu_req.op     = ALU_EQ;
        alu_req.a      = key_rdata;
        alu_req.b      = key_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    key_next       = req.object_key;
                    load_next      = req.load_from_backing;
                    res_hit_next   = 1'b0;
                    res_slot_next  = '0;
                    res_wb_next    = 1'b0;
                    res_vkey_next  = '0;
                    res_fetch_next = 1'b0;
                    rd_addr_next   = '0;
                    case (req.func)
                        FN_LOOKUP:
                        begin
                            last_next  = IDX_W'(fill_reg - 1'b1);
                            state_next = (fill_reg == '0) ? ST_FINISH : ST_LOOK;
                        end
                        FN_INSERT:
                        begin
                            if (fill_reg < FILL_W'(ENTRIES))
                            begin
                                evict_next    = 1'b0;
                                best_idx_next = IDX_W'(fill_reg);
                                state_next    = ST_INSTALL;
                            end
                            else
                            begin
                                evict_next = 1'b1;
                                last_next  = IDX_W'(ENTRIES - 1);
                                state_next = ST_EVSCAN;
                            end
                        end
                        FN_TOUCH:
                        begin
                            res_slot_next = req.target_slot;
                            rd_addr_next  = IDX_W'(req.target_slot);
                            state_next    = target_ok ? ST_TOUCH_RD : ST_FINISH;
                        end
                        FN_DIRTY:
                        begin
                            res_slot_next = req.target_slot;
                            if (target_ok)
                            begin
                                dirty_next[IDX_W'(req.target_slot)] = 1'b1;
                            end
                            state_next = ST_FINISH;
                        end
                        default: state_next = ST_FINISH;
                    endcase
                end
            end

            ST_LOOK:
            begin
                // Issue the next read while comparing the slot read last cycle
                cmp_vld_next = 1'b1;
                if (rd_addr_reg != last_reg)
                begin
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
                if (cmp_vld_reg)
                begin
                    if (alu_flag)
                    begin
                        res_hit_next  = 1'b1;
                        res_slot_next = SLOT_W'(cmp_idx_reg);
                        state_next    = ST_FINISH;
                    end
                    else if (cmp_idx_reg == last_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_EVSCAN:
            begin
                alu_req.op   = ALU_LT;
                alu_req.a    = KEY_W'(cnt_rdata);
                alu_req.b    = KEY_W'(best_cnt_reg);
                cmp_vld_next = 1'b1;
                if (rd_addr_reg != last_reg)
                begin
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
                if (cmp_vld_reg)
                begin
                    if (take_best)
                    begin
                        best_idx_next = cmp_idx_reg;
                        best_cnt_next = cnt_rdata;
                        best_key_next = key_rdata;
                    end
                    if (cmp_idx_reg == last_reg)
                    begin
                        state_next = ST_INSTALL;
                    end
                end
            end

            ST_INSTALL:
            begin
                key_we         = 1'b1;
                cnt_we         = 1'b1;
                wr_addr        = best_idx_reg;
                cnt_wdata      = '0;
                dirty_next[best_idx_reg] = 1'b0;
                if (!evict_reg)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                res_hit_next   = 1'b1;
                res_slot_next  = SLOT_W'(best_idx_reg);
                res_wb_next    = victim_dirty;
                res_vkey_next  = victim_dirty ? best_key_reg : '0;
                res_fetch_next = load_reg;
                state_next     = ST_FINISH;
            end

            ST_TOUCH_RD:
            begin
                // Count RAM read of the target slot is in flight
                state_next = ST_TOUCH_WR;
            end

            ST_TOUCH_WR:
            begin
                alu_req.op = ALU_INC;
                alu_req.a  = KEY_W'(cnt_rdata);
                alu_req.b  = '0;
                cnt_we     = 1'b1;
                wr_addr    = rd_addr_reg;
                cnt_wdata  = alu_inc;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            dirty_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            dirty_reg   <= dirty_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= rd_addr_next;
        cmp_idx_reg   <= cmp_idx_next;
        last_reg      <= last_next;
        key_reg       <= key_next;
        load_reg      <= load_next;
        evict_reg     <= evict_next;
        best_idx_reg  <= best_idx_next;
        best_cnt_reg  <= best_cnt_next;
        best_key_reg  <= best_key_next;
        res_hit_reg   <= res_hit_next;
        res_slot_reg  <= res_slot_next;
        res_wb_reg    <= res_wb_next;
        res_vkey_reg  <= res_vkey_next;
        res_fetch_reg <= res_fetch_next;
        if (out_load)
        begin
            out_hit_reg   <= res_hit_reg;
            out_slot_reg  <= res_slot_reg;
            out_wb_reg    <= res_wb_reg;
            out_vkey_reg  <= res_vkey_reg;
            out_fetch_reg <= res_fetch_reg;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= ENTRIES)
        else $error("fill level beyond table size");

    a_fill_only_install: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != $past(fill_reg) |-> $past(state_reg) == ST_INSTALL)
        else $error("fill level changed outside install");

    a_wb_implies_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.writeback |-> rsp.hit && rsp.fetch == out_fetch_reg)
        else $error("write-back reported without insert");

    a_match_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOK && cmp_vld_reg && alu_flag |=> state_reg == ST_FINISH)
        else $error("lookup scan continued after a match");

endmodule

### tb/tb_least_used_tag_cache_top.sv
// Self-checking testbench for least_used_tag_cache_top: directed and random traffic
// on the request channel, every response checked against a cycle-free model of the table.
// Depends on ltc_pkg, ltc_if and the design sources.
module tb_least_used_tag_cache_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ltc_pkg::*;

    localparam int CACHE_ENTRIES = DEF_ENTRIES;
    localparam int USE_W         = DEF_COUNT_WIDTH;
    localparam int KEY_POOL      = 24;
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int TAIL_CYCLES   = CACHE_ENTRIES + 24;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              writeback;
        logic [KEY_W-1:0]  victim;
        logic              fetch;
    } cache_result_t;

    logic clk = 1'b0;
    logic rst_n;

    ltc_req_if req_ch ();
    ltc_rsp_if rsp_ch ();

    least_used_tag_cache_top #(
        .ENTRIES     (CACHE_ENTRIES),
        .COUNT_WIDTH (USE_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // shadow copy of the tag table
    logic [KEY_W-1:0] tag_key   [CACHE_ENTRIES];
    logic [USE_W-1:0] tag_uses  [CACHE_ENTRIES];
    logic             tag_dirty [CACHE_ENTRIES];
    int               tags_filled;

    cache_result_t    pending_results[$];
    logic [KEY_W-1:0] key_pool[KEY_POOL];
    int               mismatch_count;
    bit               idle_on;
    bit               hold_rsp_long;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic cache_result_t predict_cache(func_t f, logic [KEY_W-1:0] k,
                                                    logic [SLOT_W-1:0] s, logic ld);
        cache_result_t r;
        int            victim;
        r = '0;
        victim = 0;
        case (f)
            FN_LOOKUP:
            begin
                for (int i = 0; i < tags_filled; i++)
                begin
                    if (tag_key[i] == k)
                    begin
                        r.hit  = 1'b1;
                        r.slot = i[SLOT_W-1:0];
                        break;
                    end
                end
            end
            FN_INSERT:
            begin
                r.hit   = 1'b1;
                r.fetch = ld;
                if (tags_filled < CACHE_ENTRIES)
                begin
                    victim = tags_filled;
                    tags_filled++;
                end
                else
                begin
                    // smallest count wins, lowest index on ties
                    for (int i = 1; i < CACHE_ENTRIES; i++)
                    begin
                        if (tag_uses[i] < tag_uses[victim])
                            victim = i;
                    end
                    if (tag_dirty[victim])
                    begin
                        r.writeback = 1'b1;
                        r.victim    = tag_key[victim];
                    end
                end
                r.slot            = victim[SLOT_W-1:0];
                tag_key[victim]   = k;
                tag_uses[victim]  = '0;
                tag_dirty[victim] = 1'b0;
            end
            default:
            begin
                r.slot = s;
                if (int'(s) < tags_filled)
                begin
                    if (f == FN_TOUCH)
                    begin
                        if (tag_uses[s] != '1)
                            tag_uses[s] = tag_uses[s] + 1'b1;
                    end
                    else
                        tag_dirty[s] = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_req(func_t f, logic [KEY_W-1:0] k, logic [SLOT_W-1:0] s, logic ld);
        @(negedge clk);
        req_ch.valid             <= 1'b1;
        req_ch.func              <= f;
        req_ch.object_key        <= k;
        req_ch.target_slot       <= s;
        req_ch.load_from_backing <= ld;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_cache(f, k, s, ld));
    endtask

    task automatic sender_gap(int cycles);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        sender_gap(1);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_table();
        send_req(FN_LOOKUP, '0, '0, 1'b0);
        send_req(FN_TOUCH, '1, 4'd0, 1'b1);
        send_req(FN_DIRTY, '0, 4'd15, 1'b0);
        wait_drained();
    endtask

    task automatic test_fill_and_lookup();
        send_req(FN_INSERT, '0, 4'd7, 1'b1);
        send_req(FN_INSERT, '1, 4'd0, 1'b0);
        // duplicate key: lookups must still report the first slot
        send_req(FN_INSERT, '0, 4'd0, 1'b1);
        send_req(FN_TOUCH, '0, 4'd3, 1'b0);
        send_req(FN_DIRTY, '0, 4'd9, 1'b0);
        send_req(FN_LOOKUP, '0, '1, 1'b1);
        send_req(FN_LOOKUP, '1, '0, 1'b0);
        send_req(FN_LOOKUP, 32'h1234_5678, '0, 1'b0);
        for (int i = 3; i < CACHE_ENTRIES; i++)
            send_req(FN_INSERT, $urandom, 4'($urandom), 1'($urandom));
        send_req(FN_LOOKUP, tag_key[CACHE_ENTRIES-1], '0, 1'b0);
        wait_drained();
    endtask

    task automatic test_eviction();
        send_req(FN_TOUCH, '0, 4'd0, 1'b0);
        send_req(FN_DIRTY, '0, 4'd1, 1'b0);
        send_req(FN_INSERT, 32'hAAAA_AAAA, '0, 1'b1);
        send_req(FN_DIRTY, '0, 4'd1, 1'b0);
        send_req(FN_INSERT, 32'h5555_5555, '0, 1'b0);
        send_req(FN_LOOKUP, '1, '0, 1'b0);
        send_req(FN_LOOKUP, 32'h5555_5555, '0, 1'b0);
        wait_drained();
    endtask

    // uneven use counts steer the next eviction away from slot 2
    task automatic test_count_ordering();
        for (int i = 0; i < 4; i++)
            send_req(FN_TOUCH, '0, 4'd2, 1'b0);
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            if (i != 2)
                send_req(FN_TOUCH, '0, 4'(i), 1'b0);
        end
        send_req(FN_INSERT, 32'hC0DE_0001, '0, 1'b1);
        wait_drained();
    endtask

    task automatic test_input_backpressure();
        hold_rsp_long = 1'b1;
        for (int i = 0; i < 8; i++)
            send_req(func_t'(i % 4), key_pool[i], 4'(i * 3), 1'(i));
        wait_drained();
    endtask

    task automatic test_random_traffic(int n_items);
        func_t            f;
        logic [KEY_W-1:0] k;
        int               sel;
        int               pick;
        for (int n = 0; n < n_items; n++)
        begin
            sel  = $urandom_range(0, 99);
            pick = $urandom_range(0, KEY_POOL - 1);
            if (sel < 35)
                f = FN_LOOKUP;
            else if (sel < 65)
                f = FN_INSERT;
            else if (sel < 85)
                f = FN_TOUCH;
            else
                f = FN_DIRTY;
            k = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[pick];
            if (f == FN_INSERT && $urandom_range(0, 7) == 0)
                key_pool[pick] = k;
            if (idle_on && $urandom_range(0, 3) == 0)
                sender_gap($urandom_range(1, 13));
            send_req(f, k, 4'($urandom), 1'($urandom));
        end
        wait_drained();
    endtask

    // response side: random stalls, one long hold on request
    initial
    begin : rsp_ready_gen
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp_long)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_rsp_long = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (idle_on)
                    repeat ($urandom_range(0, 12)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        cache_result_t exp_r;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("response transfer with nothing pending");
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (rsp_ch.hit !== exp_r.hit)
                begin
                    $error("hit: expected %0d, got %0d", exp_r.hit, rsp_ch.hit);
                    mismatch_count++;
                end
                if (rsp_ch.result_slot !== exp_r.slot)
                begin
                    $error("result_slot: expected %0d, got %0d", exp_r.slot, rsp_ch.result_slot);
                    mismatch_count++;
                end
                if (rsp_ch.writeback !== exp_r.writeback)
                begin
                    $error("writeback: expected %0d, got %0d", exp_r.writeback,
                           rsp_ch.writeback);
                    mismatch_count++;
                end
                if (rsp_ch.victim_key !== exp_r.victim)
                begin
                    $error("victim_key: expected %h, got %h", exp_r.victim, rsp_ch.victim_key);
                    mismatch_count++;
                end
                if (rsp_ch.fetch !== exp_r.fetch)
                begin
                    $error("fetch: expected %0d, got %0d", exp_r.fetch, rsp_ch.fetch);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no transfer for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        req_ch.valid             = 1'b0;
        req_ch.func              = FN_LOOKUP;
        req_ch.object_key        = '0;
        req_ch.target_slot       = '0;
        req_ch.load_from_backing = 1'b0;
        rst_n                    = 1'b0;
        tags_filled              = 0;
        mismatch_count           = 0;
        idle_on                  = 1'b0;
        hold_rsp_long            = 1'b0;
        key_pool[0]              = '0;
        key_pool[1]              = '1;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = $urandom;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            tag_dirty[i] = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_fill_and_lookup();
        test_eviction();
        test_count_ordering();
        idle_on = 1'b1;
        test_input_backpressure();
        test_random_traffic(1650);
        // no idling in the closing stretch
        idle_on = 1'b0;
        test_random_traffic(250);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
